/* src/amgs_pkg.sv */
// Package for the adjacency matrix graph store: item types, opcodes, status codes.
// Shared by the store, the sequencer and the top level; depends on nothing.
`default_nettype none

package amgs_pkg;

  localparam int unsigned MaxVerticesDefault = 32;
  localparam int unsigned NameWidth = 32;
  localparam int unsigned CountOutWidth = 6;

  localparam logic [1:0] OP_ADD_EDGE  = 2'd0;
  localparam logic [1:0] OP_LIST_SUCC = 2'd1;
  localparam logic [1:0] OP_LIST_PRED = 2'd2;
  localparam logic [1:0] OP_LIST_VERT = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]                  opcode;
    logic signed [NameWidth-1:0] vertex_a;
    logic signed [NameWidth-1:0] vertex_b;
  } in_item_t;

  typedef struct packed {
    logic signed [NameWidth-1:0] vertex_name;
    logic [1:0]                  status;
    logic                        last;
    logic [CountOutWidth-1:0]    vertex_count;
  } out_item_t;

endpackage

`default_nettype wire

/* src/amgs_mem.sv */
// Vertex name memory and edge bit matrix, one write and one registered read each.
// Depends on amgs_pkg for the name width.
`default_nettype none

module amgs_mem
  import amgs_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MaxVerticesDefault,
  localparam int unsigned IdxW = $clog2(MAX_VERTICES)
) (
  input  wire logic                 clk_i,
  input  wire logic                 names_we_i,
  input  wire logic [IdxW-1:0]      names_waddr_i,
  input  wire logic [NameWidth-1:0] names_wdata_i,
  input  wire logic [IdxW-1:0]      names_raddr_i,
  output logic [NameWidth-1:0]      names_rdata_o,
  input  wire logic                 edge_we_i,
  input  wire logic [IdxW-1:0]      edge_waddr_i,
  input  wire logic [MAX_VERTICES-1:0] edge_wdata_i,
  input  wire logic [IdxW-1:0]      edge_raddr_i,
  output logic [MAX_VERTICES-1:0]   edge_rdata_o
);

  logic [NameWidth-1:0]    names_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] edge_mem  [MAX_VERTICES];

  always_ff @(posedge clk_i) begin
    if (names_we_i) begin
      names_mem[names_waddr_i] <= names_wdata_i;
    end
    names_rdata_o <= names_mem[names_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we_i) begin
      edge_mem[edge_waddr_i] <= edge_wdata_i;
    end
    edge_rdata_o <= edge_mem[edge_raddr_i];
  end

endmodule

`default_nettype wire

/* src/amgs_seq.sv */
// Sequencer of the graph store: name lookup over the single name read port, vertex
// registration, edge update and list scans. Depends on amgs_pkg; drives amgs_mem.
`default_nettype none

module amgs_seq
  import amgs_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MaxVerticesDefault,
  localparam int unsigned IdxW = $clog2(MAX_VERTICES),
  localparam int unsigned CntW = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire in_item_t                in_item_i,
  input  wire logic                    emit_ok_i,
  output logic                         emit_o,
  output out_item_t                    emit_item_o,
  output logic                         names_we_o,
  output logic [IdxW-1:0]              names_waddr_o,
  output logic [NameWidth-1:0]         names_wdata_o,
  output logic [IdxW-1:0]              names_raddr_o,
  input  wire logic [NameWidth-1:0]    names_rdata_i,
  output logic                         edge_we_o,
  output logic [IdxW-1:0]              edge_waddr_o,
  output logic [MAX_VERTICES-1:0]      edge_wdata_o,
  output logic [IdxW-1:0]              edge_raddr_o,
  input  wire logic [MAX_VERTICES-1:0] edge_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_ADD_A,
    S_ADD_B,
    S_ADD_EDGE,
    S_SCAN,
    S_RESP
  } state_e;

  state_e               state_q, state_d;
  logic [1:0]           op_q, op_d;
  logic [NameWidth-1:0] a_q, a_d, b_q, b_d;
  logic [CntW-1:0]      idx_q, idx_d, cnt_q, cnt_d;
  logic [IdxW-1:0]      ia_q, ia_d, ib_q, ib_d;
  logic                 fa_q, fa_d, fb_q, fb_d, new_a_q, new_a_d, pend_q, pend_d;
  logic [NameWidth-1:0] buf_q, buf_d;
  logic [1:0]           st_q, st_d;

  logic            at_end;
  logic            match_a;
  logic            match_b;
  logic            hit;
  logic [1:0]      need;
  logic [CntW:0]   need_sum;

  assign at_end   = (idx_q >= cnt_q);
  assign match_a  = (names_rdata_i == a_q);
  assign match_b  = (names_rdata_i == b_q);
  assign need     = {1'b0, ~fa_q} + {1'b0, ~fb_q & ~(~fa_q & (a_q == b_q))};
  assign need_sum = {1'b0, cnt_q} + (CntW+1)'(need);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    case (op_q)
      OP_LIST_SUCC: hit = edge_rdata_i[idx_q[IdxW-1:0]];
      OP_LIST_PRED: hit = edge_rdata_i[ia_q];
      default:      hit = 1'b1;
    endcase
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    a_d     = a_q;
    b_d     = b_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    ia_d    = ia_q;
    ib_d    = ib_q;
    fa_d    = fa_q;
    fb_d    = fb_q;
    new_a_d = new_a_q;
    pend_d  = pend_q;
    buf_d   = buf_q;
    st_d    = st_q;

    names_we_o    = 1'b0;
    names_waddr_o = cnt_q[IdxW-1:0];
    names_wdata_o = a_q;
    edge_we_o     = 1'b0;
    edge_waddr_o  = cnt_q[IdxW-1:0];
    edge_wdata_o  = '0;
    emit_o        = 1'b0;
    emit_item_o   = '{vertex_name: '0, status: st_q, last: 1'b1,
                      vertex_count: CountOutWidth'(cnt_q)};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_item_i.opcode;
          a_d     = in_item_i.vertex_a;
          b_d     = in_item_i.vertex_b;
          idx_d   = '0;
          fa_d    = 1'b0;
          fb_d    = 1'b0;
          new_a_d = 1'b0;
          pend_d  = 1'b0;
          state_d = (in_item_i.opcode == OP_LIST_VERT) ? S_SCAN : S_LOOK;
        end
      end
      S_LOOK: begin
        if (at_end) begin
          if (op_q == OP_ADD_EDGE) begin
            state_d = S_ADD_A;
          end else begin
            st_d    = ST_UNKNOWN;
            state_d = S_RESP;
          end
        end else begin
          idx_d = idx_q + 1'b1;
          if (match_a && !fa_q) begin
            fa_d = 1'b1;
            ia_d = idx_q[IdxW-1:0];
          end
          if (match_b && !fb_q) begin
            fb_d = 1'b1;
            ib_d = idx_q[IdxW-1:0];
          end
          if (op_q != OP_ADD_EDGE && match_a) begin
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_ADD_A: begin
        if (need_sum > (CntW+1)'(MAX_VERTICES)) begin
          st_d    = ST_FULL;
          state_d = S_RESP;
        end else begin
          if (!fa_q) begin
            names_we_o    = 1'b1;
            names_wdata_o = a_q;
            edge_we_o     = 1'b1;
            ia_d          = cnt_q[IdxW-1:0];
            cnt_d         = cnt_q + 1'b1;
            new_a_d       = 1'b1;
          end
          state_d = S_ADD_B;
        end
      end
      S_ADD_B: begin
        if (!fb_q) begin
          if (new_a_q && (a_q == b_q)) begin
            ib_d = ia_q;
          end else begin
            names_we_o    = 1'b1;
            names_wdata_o = b_q;
            edge_we_o     = 1'b1;
            ib_d          = cnt_q[IdxW-1:0];
            cnt_d         = cnt_q + 1'b1;
          end
        end
        state_d = S_ADD_EDGE;
      end
      S_ADD_EDGE: begin
        edge_we_o    = 1'b1;
        edge_waddr_o = ia_q;
        edge_wdata_o = (new_a_q ? '0 : edge_rdata_i) | (MAX_VERTICES'(1) << ib_q);
        st_d         = ST_OK;
        state_d      = S_RESP;
      end
      S_SCAN: begin
        if (at_end) begin
          if (pend_q) begin
            emit_item_o.vertex_name = buf_q;
            emit_item_o.status      = ST_OK;
            if (emit_ok_i) begin
              emit_o  = 1'b1;
              state_d = S_IDLE;
            end
          end else begin
            st_d    = ST_EMPTY;
            state_d = S_RESP;
          end
        end else if (!hit) begin
          idx_d = idx_q + 1'b1;
        end else if (!pend_q) begin
          buf_d  = names_rdata_i;
          pend_d = 1'b1;
          idx_d  = idx_q + 1'b1;
        end else begin
          emit_item_o.vertex_name = buf_q;
          emit_item_o.status      = ST_OK;
          emit_item_o.last        = 1'b0;
          if (emit_ok_i) begin
            emit_o = 1'b1;
            buf_d  = names_rdata_i;
            idx_d  = idx_q + 1'b1;
          end
        end
      end
      S_RESP: begin
        if (emit_ok_i) begin
          emit_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    names_raddr_o = idx_d[IdxW-1:0];
    if (state_d == S_SCAN && op_q == OP_LIST_PRED) begin
      edge_raddr_o = idx_d[IdxW-1:0];
    end else begin
      edge_raddr_o = ia_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      fa_q    <= 1'b0;
      fb_q    <= 1'b0;
      new_a_q <= 1'b0;
      pend_q  <= 1'b0;
      op_q    <= OP_ADD_EDGE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      fa_q    <= fa_d;
      fb_q    <= fb_d;
      new_a_q <= new_a_d;
      pend_q  <= pend_d;
      op_q    <= op_d;
      st_q    <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    ia_q  <= ia_d;
    ib_q  <= ib_d;
    buf_q <= buf_d;
  end

endmodule

`default_nettype wire

/* src/adjacency_matrix_graph_store.sv */
// Directed graph store over an adjacency bit matrix of MAX_VERTICES rows.
// Add edge: name lookup, registration of new vertices, then the edge bit write; a list
// scans the registered vertices, one name per cycle while the output does not stall, set by
// the single name read port.
// One item at a time; results leave through a one-entry output register.
// Reset clears the vertex count and control; no memory clearing pass is run.
`default_nettype none

module adjacency_matrix_graph_store
  import amgs_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MaxVerticesDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int unsigned IdxW = $clog2(MAX_VERTICES);

  logic                    emit;
  logic                    emit_ok;
  out_item_t               emit_item;
  logic                    names_we;
  logic [IdxW-1:0]         names_waddr;
  logic [NameWidth-1:0]    names_wdata;
  logic [IdxW-1:0]         names_raddr;
  logic [NameWidth-1:0]    names_rdata;
  logic                    edge_we;
  logic [IdxW-1:0]         edge_waddr;
  logic [MAX_VERTICES-1:0] edge_wdata;
  logic [IdxW-1:0]         edge_raddr;
  logic [MAX_VERTICES-1:0] edge_rdata;
  logic                    out_valid_q;
  out_item_t               out_item_q;

  assign emit_ok     = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  amgs_seq #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .emit_ok_i    (emit_ok),
    .emit_o       (emit),
    .emit_item_o  (emit_item),
    .names_we_o   (names_we),
    .names_waddr_o(names_waddr),
    .names_wdata_o(names_wdata),
    .names_raddr_o(names_raddr),
    .names_rdata_i(names_rdata),
    .edge_we_o    (edge_we),
    .edge_waddr_o (edge_waddr),
    .edge_wdata_o (edge_wdata),
    .edge_raddr_o (edge_raddr),
    .edge_rdata_i (edge_rdata)
  );

  amgs_mem #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_mem (
    .clk_i        (clk_i),
    .names_we_i   (names_we),
    .names_waddr_i(names_waddr),
    .names_wdata_i(names_wdata),
    .names_raddr_i(names_raddr),
    .names_rdata_o(names_rdata),
    .edge_we_i    (edge_we),
    .edge_waddr_i (edge_waddr),
    .edge_wdata_i (edge_wdata),
    .edge_raddr_i (edge_raddr),
    .edge_rdata_o (edge_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_item_q <= emit_item;
    end
  end

endmodule

`default_nettype wire
